[hdl/bcci_pkg.sv]
// Package for the box/circle collision index: shared types, sizes and codes.
// No dependencies.
package bcci_pkg;

    localparam int MAX_BOXES   = 128;
    localparam int MAX_CIRCLES = 128;
    localparam int BOX_AW      = $clog2(MAX_BOXES);
    localparam int CIRC_AW     = $clog2(MAX_CIRCLES);
    localparam int BOX_CW      = $clog2(MAX_BOXES + 1);
    localparam int CIRC_CW     = $clog2(MAX_CIRCLES + 1);
    localparam int IDX_AW      = (BOX_AW > CIRC_AW) ? BOX_AW : CIRC_AW;

    localparam logic [14:0] AREA_RESET = 15'd8192;

    typedef enum logic [1:0] {
        MODE_INS_BOX  = 2'd0,
        MODE_INS_CIRC = 2'd1,
        MODE_TST_BOX  = 2'd2,
        MODE_TST_CIRC = 2'd3
    } mode_t;

    localparam logic CFG_AREA_W = 1'b0;
    localparam logic CFG_AREA_H = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_BOX,
        ST_SCAN_CIRC,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               load;
        logic               ins_box;
        logic               ins_circ;
        logic               rd_box;
        logic               rd_circ;
        logic [IDX_AW-1:0]  rd_idx;
        logic               eval_box;
        logic               eval_circ;
        logic               clr_hit;
    } dp_cmd_t;

    typedef struct packed {
        logic               outside;
        logic               covers;
        logic [BOX_CW-1:0]  box_count;
        logic [CIRC_CW-1:0] circ_count;
        logic               hit;
        logic               cmp_busy;
    } dp_stat_t;

endpackage

[hdl/bcci_datapath.sv]
// Datapath: query registers, box and circle memories, counts and the pipelined
// entry comparator. Depends on bcci_pkg.
module bcci_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           mode,
    input  logic signed [15:0]   min_x,
    input  logic signed [15:0]   min_y,
    input  logic signed [15:0]   max_x,
    input  logic signed [15:0]   max_y,
    input  logic signed [15:0]   center_x,
    input  logic signed [15:0]   center_y,
    input  logic [14:0]          radius,
    input  logic [14:0]          area_w,
    input  logic [14:0]          area_h,
    input  bcci_pkg::dp_cmd_t    cmd,
    output bcci_pkg::dp_stat_t   stat
);
    import bcci_pkg::*;

    logic [63:0] box_mem [MAX_BOXES];
    logic [46:0] circ_mem [MAX_CIRCLES];

    logic [1:0]         mode_reg;
    logic signed [15:0] qx0_reg, qy0_reg, qx1_reg, qy1_reg, qcx_reg, qcy_reg;
    logic [14:0]        qr_reg;
    logic [BOX_CW-1:0]  box_cnt_reg;
    logic [CIRC_CW-1:0] circ_cnt_reg;
    logic [63:0]        box_rd_reg;
    logic [46:0]        circ_rd_reg;
    logic               v1_box_reg, v1_circ_reg;
    logic               hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            qx0_reg  <= min_x;
            qy0_reg  <= min_y;
            qx1_reg  <= max_x;
            qy1_reg  <= max_y;
            qcx_reg  <= center_x;
            qcy_reg  <= center_y;
            qr_reg   <= radius;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_box)
            box_mem[box_cnt_reg[BOX_AW-1:0]] <= {qx0_reg, qy0_reg, qx1_reg, qy1_reg};
        if (cmd.rd_box)
            box_rd_reg <= box_mem[cmd.rd_idx[BOX_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_circ)
            circ_mem[circ_cnt_reg[CIRC_AW-1:0]] <= {qcx_reg, qcy_reg, qr_reg};
        if (cmd.rd_circ)
            circ_rd_reg <= circ_mem[cmd.rd_idx[CIRC_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_cnt_reg  <= '0;
            circ_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.ins_box)
                box_cnt_reg <= box_cnt_reg + 1'b1;
            if (cmd.ins_circ)
                circ_cnt_reg <= circ_cnt_reg + 1'b1;
        end
    end

    // query envelope and area checks
    logic signed [17:0] ex0, ey0, ex1, ey1, aw, ah;
    always_comb
    begin
        if (mode_reg == MODE_TST_CIRC)
        begin
            ex0 = 18'(qcx_reg) - 18'($signed({1'b0, qr_reg}));
            ey0 = 18'(qcy_reg) - 18'($signed({1'b0, qr_reg}));
            ex1 = 18'(qcx_reg) + 18'($signed({1'b0, qr_reg}));
            ey1 = 18'(qcy_reg) + 18'($signed({1'b0, qr_reg}));
        end
        else
        begin
            ex0 = 18'(qx0_reg);
            ey0 = 18'(qy0_reg);
            ex1 = 18'(qx1_reg);
            ey1 = 18'(qy1_reg);
        end
        aw = $signed({3'b000, area_w});
        ah = $signed({3'b000, area_h});
    end

    // stage 1: operand setup for the comparison of one stored entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_box_reg  <= 1'b0;
            v1_circ_reg <= 1'b0;
        end
        else
        begin
            v1_box_reg  <= cmd.eval_box;
            v1_circ_reg <= cmd.eval_circ;
        end
    end

    // select operands: box pair, circle pair or circle-box pair
    logic signed [15:0] cbx0, cby0, cbx1, cby1, ccx, ccy;
    logic [14:0]        ccr;
    logic               kind_bb, kind_cc;
    logic signed [15:0] sbx0, sby0, sbx1, sby1, scx, scy;
    logic [14:0]        sr;

    assign {sbx0, sby0, sbx1, sby1} = box_rd_reg;
    assign {scx, scy, sr}           = circ_rd_reg;

    always_comb
    begin
        kind_bb = v1_box_reg && (mode_reg == MODE_TST_BOX);
        kind_cc = v1_circ_reg && (mode_reg == MODE_TST_CIRC);
        if (v1_box_reg)
        begin
            cbx0 = sbx0; cby0 = sby0; cbx1 = sbx1; cby1 = sby1;
            ccx = qcx_reg; ccy = qcy_reg; ccr = qr_reg;
        end
        else
        begin
            cbx0 = qx0_reg; cby0 = qy0_reg; cbx1 = qx1_reg; cby1 = qy1_reg;
            ccx = scx; ccy = scy; ccr = sr;
        end
    end

    // stage A: box touch, circle differences, circle-box distances
    logic               a_v_reg, a_bb_reg, a_cc_reg, a_touch_reg;
    logic signed [17:0] a_dx_reg, a_dy_reg;
    logic [18:0]        a_rr_reg;
    logic               a_early_miss_reg, a_early_hit_reg;

    logic signed [17:0] w2, h2, r2;
    logic signed [19:0] tx, ty;
    always_comb
    begin
        w2 = 18'(cbx1) - 18'(cbx0);
        h2 = 18'(cby1) - 18'(cby0);
        r2 = $signed({2'b00, ccr, 1'b0});
        tx = 20'(ccx) * 20'sd2 - 20'(cbx0) - 20'(cbx1);
        ty = 20'(ccy) * 20'sd2 - 20'(cby0) - 20'(cby1);
    end

    logic signed [19:0] dxa, dya, w2e, h2e, r2e, exa, eya;
    always_comb
    begin
        dxa = (tx < 0) ? -tx : tx;
        dya = (ty < 0) ? -ty : ty;
        w2e = 20'(w2);
        h2e = 20'(h2);
        r2e = 20'(r2);
        exa = dxa - w2e;
        eya = dya - h2e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else
            a_v_reg <= v1_box_reg || v1_circ_reg;
    end

    always_ff @(posedge clk)
    begin
        a_bb_reg    <= kind_bb;
        a_cc_reg    <= kind_cc;
        a_touch_reg <= (qx0_reg <= sbx1) && (qy0_reg <= sby1) &&
                       (qx1_reg >= sbx0) && (qy1_reg >= sby0);
        if (kind_cc)
        begin
            a_dx_reg <= 18'(scx) - 18'(qcx_reg);
            a_dy_reg <= 18'(scy) - 18'(qcy_reg);
            a_rr_reg <= 19'(sr) + 19'(qr_reg) ;
        end
        else
        begin
            a_dx_reg <= 18'(exa);
            a_dy_reg <= 18'(eya);
            a_rr_reg <= 19'(r2e);
        end
        a_early_miss_reg <= (dxa > w2e + r2e) || (dya > h2e + r2e);
        a_early_hit_reg  <= (dxa <= w2e) || (dya <= h2e);
    end

    // stage B: squares
    logic        b_v_reg, b_bb_reg, b_cc_reg, b_touch_reg, b_em_reg, b_eh_reg;
    logic [35:0] b_sx_reg, b_sy_reg;
    logic [37:0] b_sr_reg;

    logic signed [35:0] sq_x, sq_y;
    always_comb
    begin
        sq_x = a_dx_reg * a_dx_reg;
        sq_y = a_dy_reg * a_dy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        b_bb_reg    <= a_bb_reg;
        b_cc_reg    <= a_cc_reg;
        b_touch_reg <= a_touch_reg;
        b_em_reg    <= a_early_miss_reg;
        b_eh_reg    <= a_early_hit_reg;
        b_sx_reg    <= $unsigned(sq_x);
        b_sy_reg    <= $unsigned(sq_y);
        b_sr_reg    <= a_rr_reg * a_rr_reg;
    end

    logic [36:0] sum_sq;
    logic        b_hit;
    always_comb
    begin
        sum_sq = 37'(b_sx_reg) + 37'(b_sy_reg);
        if (b_bb_reg)
            b_hit = b_touch_reg;
        else if (b_cc_reg)
            b_hit = 38'(sum_sq) < b_sr_reg;
        else
            b_hit = !b_em_reg && (b_eh_reg || 38'(sum_sq) <= b_sr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (cmd.clr_hit)
            hit_reg <= 1'b0;
        else if (b_v_reg && b_hit)
            hit_reg <= 1'b1;
    end

    assign stat.outside    = (ex1 < 0) || (ex0 >= aw) || (ey1 < 0) || (ey0 >= ah);
    assign stat.covers     = (ex0 <= 0) && (ey0 <= 0) && (aw <= ex1) && (ah <= ey1);
    assign stat.box_count  = box_cnt_reg;
    assign stat.circ_count = circ_cnt_reg;
    assign stat.hit        = hit_reg;
    assign stat.cmp_busy   = v1_box_reg || v1_circ_reg || a_v_reg || b_v_reg ||
                             cmd.eval_box || cmd.eval_circ;

endmodule

[hdl/bcci_ctrl.sv]
// Controller: accepts a transaction, sequences inserts and table scans,
// and holds the result register. Depends on bcci_pkg.
module bcci_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic               status,
    output bcci_pkg::dp_cmd_t  cmd,
    input  bcci_pkg::dp_stat_t stat
);
    import bcci_pkg::*;

    state_t             state_reg, state_next;
    logic [1:0]         mode_reg;
    logic [IDX_AW:0]    idx_reg, idx_next;
    logic               out_valid_reg, hit_reg, status_reg;
    logic               accept, first_reg;
    logic               fin, fin_hit, fin_status;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            mode_reg  <= MODE_INS_BOX;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            first_reg <= accept;
            if (accept)
                mode_reg <= mode;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (first_reg)
                begin
                    if (mode_reg inside {MODE_INS_BOX, MODE_INS_CIRC} ||
                        stat.outside || stat.covers)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN_BOX;
                end
            end
            ST_SCAN_BOX:
            begin
                if (stat.hit || idx_reg >= (IDX_AW+1)'(stat.box_count))
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN_CIRC;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_SCAN_CIRC:
            begin
                if (stat.hit || idx_reg >= (IDX_AW+1)'(stat.circ_count))
                    state_next = ST_DRAIN;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (!stat.cmp_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // read data lands in the cycle after the read strobe, together with the compare
    always_comb
    begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.clr_hit   = accept;
        cmd.rd_idx    = idx_reg[IDX_AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (first_reg && mode_reg == MODE_INS_BOX &&
                    stat.box_count < BOX_CW'(MAX_BOXES))
                    cmd.ins_box = 1'b1;
                if (first_reg && mode_reg == MODE_INS_CIRC &&
                    stat.circ_count < CIRC_CW'(MAX_CIRCLES))
                    cmd.ins_circ = 1'b1;
            end
            ST_SCAN_BOX:
            begin
                if (!stat.hit && idx_reg < (IDX_AW+1)'(stat.box_count))
                    cmd.rd_box = 1'b1;
            end
            ST_SCAN_CIRC:
            begin
                if (!stat.hit && idx_reg < (IDX_AW+1)'(stat.circ_count))
                    cmd.rd_circ = 1'b1;
            end
            default:
            begin
            end
        endcase
        cmd.eval_box  = cmd.rd_box;
        cmd.eval_circ = cmd.rd_circ;
    end

    // latch the result for the finishing transaction
    logic res_hit_reg, res_status_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && first_reg)
        begin
            res_status_reg <= (mode_reg == MODE_INS_BOX &&
                               stat.box_count >= BOX_CW'(MAX_BOXES)) ||
                              (mode_reg == MODE_INS_CIRC &&
                               stat.circ_count >= CIRC_CW'(MAX_CIRCLES));
            res_hit_reg    <= (mode_reg inside {MODE_TST_BOX, MODE_TST_CIRC}) &&
                              !stat.outside && stat.covers &&
                              (stat.box_count != '0 || stat.circ_count != '0);
        end
        else if (state_reg == ST_DRAIN && !stat.cmp_busy)
            res_hit_reg <= stat.hit;
    end

    assign fin        = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign fin_hit    = res_hit_reg;
    assign fin_status = res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            hit_reg    <= fin_hit;
            status_reg <= fin_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign status    = status_reg;

endmodule

[hdl/box_circle_collision_index_core.sv]
// Top level of the box/circle collision index: configuration registers,
// controller and datapath. Depends on bcci_pkg, bcci_ctrl, bcci_datapath.
//
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, mode .. radius       | in, stall out
//  out     | out_valid, out_stall, hit, status        | out, stall in
//  cfg     | cfg_we, cfg_index, cfg_data              | in
//
// An insert gives its result from the done state after acceptance; the next
// transaction is taken once the controller is back in idle. Unless the query
// lies outside the area or covers it, a test scans the box table and then the
// circle table, one stored entry per cycle through a 3-stage compare pipeline,
// and stops early on a hit. A waiting result only holds back the finish of the
// next transaction. Reset clears counts and control; the tables need no clearing.
module box_circle_collision_index_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic signed [15:0] min_x,
    input  logic signed [15:0] min_y,
    input  logic signed [15:0] max_x,
    input  logic signed [15:0] max_y,
    input  logic signed [15:0] center_x,
    input  logic signed [15:0] center_y,
    input  logic [14:0]        radius,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic               status,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [14:0]        cfg_data
);
    import bcci_pkg::*;

    logic [14:0] area_w_reg, area_h_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_w_reg <= AREA_RESET;
            area_h_reg <= AREA_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_AREA_W)
                area_w_reg <= cfg_data;
            if (cfg_index == CFG_AREA_H)
                area_h_reg <= cfg_data;
        end
    end

    bcci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .status    (status),
        .cmd       (cmd),
        .stat      (stat)
    );

    bcci_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode),
        .min_x    (min_x),
        .min_y    (min_y),
        .max_x    (max_x),
        .max_y    (max_y),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .area_w   (area_w_reg),
        .area_h   (area_h_reg),
        .cmd      (cmd),
        .stat     (stat)
    );

`ifndef ASSERT_OFF
    a_no_overflow_box: assert property (@(posedge clk) disable iff (!rst_n)
        stat.box_count <= BOX_CW'(MAX_BOXES)) else $error("box count overflow");
    a_no_overflow_circ: assert property (@(posedge clk) disable iff (!rst_n)
        stat.circ_count <= CIRC_CW'(MAX_CIRCLES)) else $error("circle count overflow");
    a_status_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && status)) else $error("hit and status together");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall) else $error("accept while busy");
`endif

endmodule
